@@ rtl/cft_pkg.sv @@
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int WS_DEPTH = 16;
    localparam int WS_PW    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam int WS_CW    = $clog2(WS_DEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_in;
        logic       has_byte;
        logic       line_end;
    } item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       field_end;
        logic       line_done;
        logic       ws_overflow;
        logic       last_of_run;
    } result_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_PRE  = 5'b00010,
        PH_REP  = 5'b00100,
        PH_B1   = 5'b01000,
        PH_END  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic pre;
        logic rep;
        logic b1;
        logic c2;
    } plan_t;

    typedef struct packed {
        logic   accept;
        logic   emit;
        logic   last;
        phase_t phase;
    } cft_cmd_t;

    typedef struct packed {
        plan_t fresh;
        plan_t held;
        logic  rep_more;
        logic  out_valid;
    } cft_stat_t;

endpackage

@@ rtl/cft_dp.sv @@
// ----------------------------------------------------------------------------
// cft_dp
// Parse state, held whitespace buffer, per-request plan and result register.
// ----------------------------------------------------------------------------
module cft_dp
    import cft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     item,
    input  cft_cmd_t  cmd,
    input  logic      result_stall,
    output cft_stat_t stat,
    output logic      result_valid,
    output result_t   result
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    typedef enum logic [4:0] {
        M_LINE   = 5'b00001,
        M_FSTART = 5'b00010,
        M_PLAIN  = 5'b00100,
        M_QUOTED = 5'b01000,
        M_REOPEN = 5'b10000
    } mode_t;

    function automatic logic is_ws(logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    mode_t            mode_reg, mode_next;
    logic             qk_reg, qk_next;
    logic             qp_reg, qp_next;
    logic             esc_reg, esc_next;
    logic             cs_reg, cs_next;
    logic             cmt_reg, cmt_next;
    logic [WS_CW-1:0] cnt_reg, cnt_next;
    logic [WS_PW-1:0] head_reg, head_next;
    logic [7:0]       hold_mem_reg [WS_DEPTH];

    logic             pre_reg, b1_reg, c2_reg, b1_ovf_reg;
    logic [WS_CW-1:0] rep_left_reg, rep_left_next;
    logic [7:0]       b1_val_reg;
    logic             result_valid_reg;
    result_t          result_reg, result_next;

    logic             pre, put, do_start, do_plain, do_quoted;
    logic             b1, ovf, wr, c2, head_adv;
    logic [WS_CW-1:0] rep_n;
    logic [7:0]       b;
    logic [7:0]       held_byte;
    logic [WS_PW-1:0] head_inc, tail;
    logic [WS_CW:0]   tail_sum;
    logic             rep_emit;

    assign b         = item.byte_in;
    assign held_byte = hold_mem_reg[head_reg];
    assign head_inc  = (head_reg == WS_PW'(WS_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum  = (WS_CW + 1)'(head_reg) + (WS_CW + 1)'(cnt_reg);
    assign tail      = (tail_sum >= (WS_CW + 1)'(WS_DEPTH))
                     ? WS_PW'(tail_sum - (WS_CW + 1)'(WS_DEPTH)) : WS_PW'(tail_sum);
    assign rep_emit  = cmd.emit && (cmd.phase == PH_REP);

    always_comb
    begin
        mode_next = mode_reg;
        qk_next   = qk_reg;
        qp_next   = qp_reg;
        esc_next  = esc_reg;
        cs_next   = cs_reg;
        cmt_next  = cmt_reg;
        cnt_next  = cnt_reg;
        pre       = 1'b0;
        put       = 1'b0;
        do_start  = 1'b0;
        do_plain  = 1'b0;
        do_quoted = 1'b0;
        rep_n     = '0;
        b1        = 1'b0;
        ovf       = 1'b0;
        wr        = 1'b0;
        c2        = 1'b0;
        head_adv  = 1'b0;

        if (item.has_byte && !cmt_reg)
        begin
            unique case (mode_reg)
                M_LINE:
                begin
                    if (b == CH_HASH)
                        cmt_next = 1'b1;
                    else
                        do_start = 1'b1;
                end
                M_PLAIN:
                    do_plain = 1'b1;
                M_QUOTED:
                begin
                    if (qp_reg)
                    begin
                        qp_next = 1'b0;
                        if (!qk_reg)
                        begin
                            if (b == CH_DQUOTE)
                                put = 1'b1;
                            else
                            begin
                                pre      = 1'b1;
                                do_start = (b != CH_COMMA);
                            end
                        end
                        else if (b != CH_DQUOTE)
                            do_quoted = 1'b1;
                    end
                    else
                        do_quoted = 1'b1;
                end
                M_REOPEN:
                begin
                    pre       = 1'b1;
                    do_quoted = 1'b1;
                end
                default:
                    do_start = 1'b1;
            endcase

            if (pre)
            begin
                cs_next   = 1'b0;
                cnt_next  = '0;
                esc_next  = 1'b0;
                qp_next   = 1'b0;
                mode_next = M_FSTART;
            end

            if (mode_reg == M_REOPEN)
            begin
                mode_next = M_QUOTED;
                qk_next   = 1'b1;
            end

            if (do_start)
            begin
                if (b == CH_DQUOTE || b == CH_PIPE)
                begin
                    mode_next = M_QUOTED;
                    qk_next   = (b == CH_PIPE);
                    qp_next   = 1'b0;
                    esc_next  = 1'b0;
                end
                else
                begin
                    mode_next = M_PLAIN;
                    do_plain  = 1'b1;
                end
            end

            if (do_plain)
            begin
                if (b == CH_COMMA)
                begin
                    pre       = 1'b1;
                    cs_next   = 1'b0;
                    cnt_next  = '0;
                    esc_next  = 1'b0;
                    qp_next   = 1'b0;
                    mode_next = M_FSTART;
                end
                else
                    put = 1'b1;
            end

            if (do_quoted)
            begin
                if (esc_next)
                begin
                    esc_next = 1'b0;
                    put      = 1'b1;
                end
                else if (b == CH_BSLASH)
                    esc_next = 1'b1;
                else if (b == CH_DQUOTE)
                begin
                    put     = qk_next;
                    qp_next = 1'b1;
                end
                else if (b == CH_PIPE && qk_next)
                    mode_next = M_REOPEN;
                else
                    put = 1'b1;
            end

            if (put && b != CH_NUL)
            begin
                if (is_ws(b))
                begin
                    if (cs_next)
                    begin
                        wr = 1'b1;
                        if (cnt_next == WS_CW'(WS_DEPTH))
                        begin
                            b1       = 1'b1;
                            ovf      = 1'b1;
                            head_adv = 1'b1;
                        end
                        else
                            cnt_next = cnt_next + 1'b1;
                    end
                end
                else
                begin
                    rep_n    = cnt_next;
                    b1       = 1'b1;
                    cnt_next = '0;
                    cs_next  = 1'b1;
                end
            end
        end

        if (item.line_end)
        begin
            c2        = !cmt_next;
            cmt_next  = 1'b0;
            mode_next = M_LINE;
            cnt_next  = '0;
            cs_next   = 1'b0;
            esc_next  = 1'b0;
            qp_next   = 1'b0;
        end
    end

    always_comb
    begin
        if (cmd.accept && head_adv)
            head_next = head_inc;
        else if (rep_emit)
            head_next = head_inc;
        else
            head_next = head_reg;

        if (cmd.accept)
            rep_left_next = rep_n;
        else if (rep_emit)
            rep_left_next = rep_left_reg - 1'b1;
        else
            rep_left_next = rep_left_reg;
    end

    always_comb
    begin
        result_next             = '0;
        result_next.last_of_run = cmd.last;
        unique case (cmd.phase)
            PH_PRE:
                result_next.field_end = 1'b1;
            PH_REP:
            begin
                result_next.byte_out   = held_byte;
                result_next.byte_valid = 1'b1;
            end
            PH_B1:
            begin
                result_next.byte_out    = b1_val_reg;
                result_next.byte_valid  = 1'b1;
                result_next.field_end   = c2_reg;
                result_next.line_done   = c2_reg;
                result_next.ws_overflow = b1_ovf_reg;
            end
            PH_END:
            begin
                result_next.field_end = 1'b1;
                result_next.line_done = 1'b1;
            end
            default:
                result_next.last_of_run = cmd.last;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= M_LINE;
            qk_reg           <= 1'b0;
            qp_reg           <= 1'b0;
            esc_reg          <= 1'b0;
            cs_reg           <= 1'b0;
            cmt_reg          <= 1'b0;
            cnt_reg          <= '0;
            head_reg         <= '0;
            pre_reg          <= 1'b0;
            b1_reg           <= 1'b0;
            c2_reg           <= 1'b0;
            b1_ovf_reg       <= 1'b0;
            rep_left_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                mode_reg   <= mode_next;
                qk_reg     <= qk_next;
                qp_reg     <= qp_next;
                esc_reg    <= esc_next;
                cs_reg     <= cs_next;
                cmt_reg    <= cmt_next;
                cnt_reg    <= cnt_next;
                pre_reg    <= pre;
                b1_reg     <= b1;
                c2_reg     <= c2;
                b1_ovf_reg <= ovf;
            end
            head_reg         <= head_next;
            rep_left_reg     <= rep_left_next;
            result_valid_reg <= cmd.emit || (result_valid_reg && result_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            b1_val_reg <= ovf ? held_byte : b;
        if (cmd.accept && wr)
            hold_mem_reg[tail] <= b;
        if (cmd.emit)
            result_reg <= result_next;
    end

    assign stat.fresh     = '{pre: pre, rep: (rep_n != '0), b1: b1, c2: c2};
    assign stat.held      = '{pre: pre_reg, rep: (rep_left_reg != '0), b1: b1_reg, c2: c2_reg};
    assign stat.rep_more  = (rep_left_reg > WS_CW'(1));
    assign stat.out_valid = result_valid_reg;
    assign result_valid   = result_valid_reg;
    assign result         = result_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= WS_CW'(WS_DEPTH))
        else $error("held count above buffer depth");

    a_hold_needs_content: assert property (@(posedge clk) disable iff (!rst_n)
        !cs_reg |-> (cnt_reg == '0))
        else $error("whitespace held before any content");

    a_comment_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmt_reg |-> (mode_reg == M_LINE))
        else $error("comment line left line-start mode");

endmodule

@@ rtl/cft_ctrl.sv @@
// ----------------------------------------------------------------------------
// cft_ctrl
// Sequencer: steps through the results of one request, one per cycle while the result channel does not stall.
// ----------------------------------------------------------------------------
module cft_ctrl
    import cft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      result_stall,
    input  cft_stat_t stat,
    output logic      item_stall,
    output cft_cmd_t  cmd
);

    function automatic phase_t first_phase(plan_t p);
        if (p.pre)
            return PH_PRE;
        else if (p.rep)
            return PH_REP;
        else if (p.b1)
            return PH_B1;
        else if (p.c2)
            return PH_END;
        else
            return PH_IDLE;
    endfunction

    phase_t state_reg, state_next;
    phase_t after_emit;
    logic   emit, final_emit, accept;

    always_comb
    begin
        unique case (state_reg)
            PH_PRE:
                after_emit = first_phase('{pre: 1'b0, rep: stat.held.rep,
                                           b1: stat.held.b1, c2: stat.held.c2});
            PH_REP:
                after_emit = stat.rep_more ? PH_REP
                           : first_phase('{pre: 1'b0, rep: 1'b0,
                                           b1: stat.held.b1, c2: stat.held.c2});
            PH_B1:
                after_emit = PH_IDLE;
            PH_END:
                after_emit = PH_IDLE;
            default:
                after_emit = PH_IDLE;
        endcase
    end

    assign emit       = (state_reg != PH_IDLE) && (!stat.out_valid || !result_stall);
    assign final_emit = emit && (after_emit == PH_IDLE);
    assign item_stall = !((state_reg == PH_IDLE) || final_emit);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
            state_next = first_phase(stat.fresh);
        else if (emit)
            state_next = after_emit;
        else
            state_next = state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PH_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd.accept = accept;
    assign cmd.emit   = emit;
    assign cmd.last   = final_emit;
    assign cmd.phase  = state_reg;

    a_empty_plan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (stat.fresh == '0) |=> (state_reg == PH_IDLE))
        else $error("request without results left the sequencer busy");

    a_replay_then_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_REP) |-> stat.held.b1)
        else $error("whitespace replay without a following byte");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit && final_emit && !accept |=> (state_reg == PH_IDLE))
        else $error("sequencer busy after last result of request");

endmodule

@@ rtl/csv_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV field splitter: unquotes, trims and marks fields and lines.
// Flow: a request's plan is registered on accept, then its results are
//   loaded into the result register one after another; the next request
//   is taken in the cycle its predecessor's last result is loaded.
//   Replay of held whitespace (up to WS_DEPTH bytes) gives the longest run.
// Reset: async, clears parse state, held count and sequencer; no sweep.
// ----------------------------------------------------------------------------
module csv_field_tokenizer
    import cft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    cft_cmd_t  cmd;
    cft_stat_t stat;

    cft_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .item_stall   (item_stall),
        .cmd          (cmd)
    );

    cft_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csv_field_tokenizer. A directed table covers the
// empty line, byte extremes, comments, quote and pipe fields, escapes and
// late openers. Random CSV lines follow, most of them well formed, with long
// whitespace runs for overflow and some raw noise. Every request is run
// through a local tokenizer model and each result is checked in order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import cft_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RAND_ITEMS  = 430;
    localparam logic [7:0]  CH_DQ       = 8'h22;
    localparam logic [7:0]  CH_PIPE     = 8'h7C;
    localparam logic [7:0]  CH_COMMA    = 8'h2C;
    localparam logic [7:0]  CH_BSL      = 8'h5C;
    localparam logic [7:0]  CH_HASH     = 8'h23;
    localparam logic [7:0]  CH_NUL      = 8'h00;

    typedef enum logic [2:0] {
        PM_LINE,
        PM_FSTART,
        PM_PLAIN,
        PM_QUOTED,
        PM_REOPEN
    } pmode_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    bit      row_typed = 1'b0;
    result_t row_want = '0;
    bit      quiet = 1'b0;
    int      errors = 0;
    int      cycle_cnt = 0;
    int      real_items = 0;

    // tokenizer model state
    pmode_t      pm;
    bit          qkind, qpend, esc, seen, cmt;
    logic [7:0]  held [WS_DEPTH];
    int          hcnt;
    result_t     run_q[$];
    result_t     token_q[$];

    row_t        rows[$];
    item_t       stim_q[$];

    csv_field_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    function automatic result_t mk_res(logic [7:0] b, bit v, bit fe, bit ld, bit ov, bit last);
        result_t r;
        r.byte_out    = b;
        r.byte_valid  = v;
        r.field_end   = fe;
        r.line_done   = ld;
        r.ws_overflow = ov;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic bit is_space(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void put_content(logic [7:0] b);
        if (b == CH_NUL)
            return;
        if (is_space(b))
        begin
            if (!seen)
                return;
            if (hcnt >= WS_DEPTH)
            begin
                run_q.insert(run_q.size(), mk_res(held[0], 1, 0, 0, 1, 0));
                for (int i = 0; i < WS_DEPTH - 1; i++)
                    held[i] = held[i + 1];
                hcnt = WS_DEPTH - 1;
            end
            held[hcnt] = b;
            hcnt++;
            return;
        end
        for (int i = 0; i < hcnt; i++)
            run_q.insert(run_q.size(), mk_res(held[i], 1, 0, 0, 0, 0));
        hcnt = 0;
        run_q.insert(run_q.size(), mk_res(b, 1, 0, 0, 0, 0));
        seen = 1;
    endfunction

    function automatic void close_field(bit ld);
        hcnt  = 0;
        seen  = 0;
        esc   = 0;
        qpend = 0;
        if (run_q.size() > 0 && run_q[run_q.size() - 1].byte_valid &&
            !run_q[run_q.size() - 1].field_end)
        begin
            run_q[run_q.size() - 1].field_end = 1'b1;
            run_q[run_q.size() - 1].line_done = ld;
        end
        else
            run_q.insert(run_q.size(), mk_res(8'h00, 0, 1, ld, 0, 0));
        pm = ld ? PM_LINE : PM_FSTART;
    endfunction

    function automatic void plain_byte(logic [7:0] b);
        if (b == CH_COMMA)
            close_field(0);
        else
            put_content(b);
    endfunction

    function automatic void start_byte(logic [7:0] b);
        if (b == CH_DQ || b == CH_PIPE)
        begin
            pm    = PM_QUOTED;
            qkind = (b == CH_PIPE);
            qpend = 0;
            esc   = 0;
        end
        else
        begin
            pm = PM_PLAIN;
            plain_byte(b);
        end
    endfunction

    function automatic void quoted_byte(logic [7:0] b);
        if (esc)
        begin
            esc = 0;
            put_content(b);
        end
        else if (b == CH_BSL)
            esc = 1;
        else if (b == CH_DQ)
        begin
            if (qkind)
                put_content(CH_DQ);
            qpend = 1;
        end
        else if (b == CH_PIPE && qkind)
            pm = PM_REOPEN;
        else
            put_content(b);
    endfunction

    function automatic void take_byte(logic [7:0] b);
        case (pm)
            PM_LINE:
                if (b == CH_HASH)
                    cmt = 1;
                else
                    start_byte(b);
            PM_PLAIN:
                plain_byte(b);
            PM_QUOTED:
                if (qpend)
                begin
                    qpend = 0;
                    if (!qkind)
                    begin
                        if (b == CH_DQ)
                            put_content(CH_DQ);
                        else
                        begin
                            close_field(0);
                            if (b != CH_COMMA)
                                start_byte(b);
                        end
                    end
                    else if (b != CH_DQ)
                        quoted_byte(b);
                end
                else
                    quoted_byte(b);
            PM_REOPEN:
            begin
                close_field(0);
                pm    = PM_QUOTED;
                qkind = 1;
                quoted_byte(b);
            end
            default:
                start_byte(b);
        endcase
    endfunction

    function automatic void tokenize_item(item_t it);
        run_q.delete();
        if (it.has_byte && !cmt)
            take_byte(it.byte_in);
        if (it.line_end)
        begin
            if (cmt)
            begin
                cmt   = 0;
                pm    = PM_LINE;
                hcnt  = 0;
                seen  = 0;
                esc   = 0;
                qpend = 0;
            end
            else
                close_field(1);
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic note_mismatch(string msg);
        errors++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    // request and result monitor
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (token_q.size() == 0)
                    note_mismatch($sformatf("unexpected result %p", result));
                else
                begin
                    w = token_q.pop_front();
                    if (result !== w)
                        note_mismatch($sformatf("got %p want %p", result, w));
                end
            end
            if (item_valid && !item_stall)
            begin
                tokenize_item(item);
                if (row_typed)
                    token_q.insert(token_q.size(), row_want);
                else
                    foreach (run_q[i])
                        token_q.insert(token_q.size(), run_q[i]);
            end
        end
    end

    always @(negedge clk)
        result_stall <= !quiet && ($urandom_range(0, 99) < 33);

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_row(logic [7:0] b, bit hb, bit le);
        rows.insert(rows.size(),
                    '{it: '{byte_in: b, has_byte: hb, line_end: le}, typed: 0, want: '0});
    endtask

    task automatic add_typed(logic [7:0] b, bit hb, bit le, result_t w);
        rows.insert(rows.size(),
                    '{it: '{byte_in: b, has_byte: hb, line_end: le}, typed: 1, want: w});
    endtask

    task automatic push_item(logic [7:0] b, bit hb, bit le);
        stim_q.insert(stim_q.size(), '{byte_in: b, has_byte: hb, line_end: le});
        if (hb || le)
            real_items++;
    endtask

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 6);
        return (r >= 5) ? 8'h20 : 8'h09 + r[7:0];
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 50)
            return 8'h30 + 8'($urandom_range(0, 9));
        else if (r < 66)
            return pick_space();
        else if (r < 70)
            return CH_NUL;
        else if (r < 77)
            return CH_COMMA;
        else if (r < 84)
            return CH_DQ;
        else if (r < 89)
            return CH_PIPE;
        else if (r < 94)
            return CH_BSL;
        else
            return 8'($urandom());
    endfunction

    task automatic gen_line();
        logic [7:0] lb[$];
        int         kind, nf, fk, n;
        bit         attach;
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            lb.insert(lb.size(), CH_HASH);
            n = $urandom_range(0, 6);
            repeat (n) lb.insert(lb.size(), pick_char());
        end
        else if (kind < 12)
        begin
            n = $urandom_range(1, 8);
            repeat (n) push_item(8'($urandom()), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
            return;
        end
        else if (kind >= 17)
        begin
            nf = $urandom_range(1, 4);
            for (int f = 0; f < nf; f++)
            begin
                fk = $urandom_range(0, 2);
                if (f > 0)
                    lb.insert(lb.size(), CH_COMMA);
                if (fk == 0 && $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) lb.insert(lb.size(), pick_space());
                if (fk == 1)
                    lb.insert(lb.size(), CH_DQ);
                else if (fk == 2)
                    lb.insert(lb.size(), CH_PIPE);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 99) < 7)
                        repeat ($urandom_range(14, 20)) lb.insert(lb.size(), pick_space());
                    else
                        lb.insert(lb.size(), pick_char());
                end
                if (fk == 0 && $urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) lb.insert(lb.size(), pick_space());
                if (fk == 1 && $urandom_range(0, 9) != 0)
                    lb.insert(lb.size(), CH_DQ);
                else if (fk == 2 && $urandom_range(0, 1) == 0)
                    lb.insert(lb.size(), CH_PIPE);
            end
        end
        attach = lb.size() > 0 && $urandom_range(0, 99) < 70;
        foreach (lb[i])
        begin
            if ($urandom_range(0, 99) < 5)
                push_item(8'($urandom()), 1'b0, 1'b0);
            push_item(lb[i], 1'b1, attach && i == lb.size() - 1);
        end
        if (!attach)
            push_item(8'($urandom()), 1'b0, 1'b1);
    endtask

    task automatic send(item_t it, bit typed, result_t w);
        while (!quiet && $urandom_range(0, 99) < 33)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= it;
        row_typed  <= typed;
        row_want   <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        pm    = PM_LINE;
        qkind = 0;
        qpend = 0;
        esc   = 0;
        seen  = 0;
        cmt   = 0;
        hcnt  = 0;
        foreach (held[i])
            held[i] = 8'h00;

        // empty line, byte extremes, NUL, idle request
        add_typed(8'h00, 0, 1, mk_res(8'h00, 0, 1, 1, 0, 1));
        add_typed(8'hFF, 1, 1, mk_res(8'hFF, 1, 1, 1, 0, 1));
        add_typed(CH_NUL, 1, 1, mk_res(8'h00, 0, 1, 1, 0, 1));
        add_row(8'h55, 0, 0);
        // comment line
        add_row(CH_HASH, 1, 0);
        add_row(CH_COMMA, 1, 1);
        // quoted field: doubled quote, closing quote eats comma
        add_row(CH_DQ, 1, 0);
        add_row(8'h61, 1, 0);
        add_row(CH_DQ, 1, 0);
        add_row(CH_DQ, 1, 0);
        add_row(CH_DQ, 1, 0);
        add_row(CH_COMMA, 1, 0);
        add_row(8'h62, 1, 1);
        // pipe field: quote is content, closing pipe reopens, pipe at line end
        add_row(CH_PIPE, 1, 0);
        add_row(CH_DQ, 1, 0);
        add_row(CH_DQ, 1, 0);
        add_row(CH_PIPE, 1, 0);
        add_row(CH_PIPE, 1, 1);
        // backslash at line end
        add_row(CH_DQ, 1, 0);
        add_row(CH_BSL, 1, 1);
        // leading and trailing whitespace, late opener
        add_row(8'h20, 1, 0);
        add_row(8'h61, 1, 0);
        add_row(8'h09, 1, 0);
        add_row(CH_DQ, 1, 0);
        add_row(8'h0D, 1, 0);
        add_row(8'h00, 0, 1);

        while (real_items < RAND_ITEMS)
            gen_line();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send(rows[i].it, rows[i].typed, rows[i].want);
        foreach (stim_q[i])
        begin
            quiet <= (i >= 150 && i < 260);
            send(stim_q[i], 1'b0, '0);
        end
        item_valid <= 1'b0;
        quiet      <= 1'b0;

        while (token_q.size() != 0)
            @(posedge clk);
        repeat (WS_DEPTH + 8) @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
